[sv/iceop_pkg.sv]
`timescale 1ns / 1ps

package iceop_pkg;

  localparam int EXT_HEADER_BYTES_DEF = 4;
  localparam int MIN_OBJECT_BYTES_DEF = 8;

  // Bytes taken by the object header: length (2), class number and C-type.
  localparam logic [15:0] OBJ_HEADER_BYTES = 16'd4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [15:0] total_length;
    logic        packet_start;
    logic [7:0]  data_byte;
  } iceop_item_t;

  typedef struct packed {
    logic        object_last;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] payload_length;
    logic [7:0]  class_type;
    logic [7:0]  class_num;
  } iceop_result_t;

endpackage

[sv/iceop_in_stage.sv]
`timescale 1ns / 1ps

module iceop_in_stage
  import iceop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  iceop_item_t in_item,
  output logic        held_valid,
  input  logic        held_take,
  output iceop_item_t held_item
);

  // The stage refills in the same cycle that the walker takes its item.
  assign in_ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

[sv/iceop_walker.sv]
`timescale 1ns / 1ps

module iceop_walker
  import iceop_pkg::*;
#(
  parameter int EXT_HEADER_BYTES = EXT_HEADER_BYTES_DEF,
  parameter int MIN_OBJECT_BYTES = MIN_OBJECT_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_take,
  input  iceop_item_t   item,
  output logic          res_valid,
  input  logic          res_ready,
  output iceop_result_t res
);

  typedef enum logic [2:0] {
    PH_STOPPED,
    PH_HEADER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_CLASS,
    PH_CTYPE,
    PH_KEEP,
    PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [15:0] latched_length, latched_length_next;
  logic [15:0] object_length, object_length_next;
  logic [15:0] object_remaining, object_remaining_next;
  logic [7:0]  held_class_num, held_class_num_next;
  logic [7:0]  held_class_type, held_class_type_next;

  logic          emit;
  iceop_result_t res_next;
  phase_t        cur_phase;
  logic [15:0]   off;
  logic [15:0]   len;
  logic [15:0]   full_len;
  logic [15:0]   plen;
  logic [16:0]  end_sum;

  assign item_take = item_valid && (!res_valid || res_ready);

  always_comb begin
    off       = item.packet_start ? 16'd0 : byte_offset;
    len       = item.packet_start ? item.total_length : latched_length;
    cur_phase = item.packet_start ? PH_HEADER : phase;
    if (cur_phase == PH_HEADER && off >= 16'(EXT_HEADER_BYTES)) begin
      cur_phase = PH_LEN_HI;
    end

    full_len = {object_length[15:8], item.data_byte};
    end_sum  = {1'b0, off - 16'd1} + {1'b0, full_len};
    plen     = object_length - OBJ_HEADER_BYTES;

    phase_next            = cur_phase;
    object_length_next    = object_length;
    object_remaining_next = object_remaining;
    held_class_num_next   = held_class_num;
    held_class_type_next  = held_class_type;
    emit                  = 1'b0;

    res_next.class_num      = held_class_num;
    res_next.class_type     = held_class_type;
    res_next.payload_length = plen;
    res_next.payload_index  = plen - object_remaining;
    res_next.payload_byte   = item.data_byte;
    res_next.object_last    = (object_remaining == 16'd1);

    case (cur_phase)
      PH_LEN_HI: begin
        // No more than a whole object header left: the walk ends here.
        if ({1'b0, off} + 17'd4 >= {1'b0, len}) begin
          phase_next = PH_STOPPED;
        end else begin
          object_length_next = {item.data_byte, 8'd0};
          phase_next         = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        object_length_next = full_len;
        if (full_len < OBJ_HEADER_BYTES || end_sum > {1'b0, len}) begin
          phase_next = PH_STOPPED;
        end else begin
          phase_next = PH_CLASS;
        end
      end
      PH_CLASS: begin
        held_class_num_next = item.data_byte;
        phase_next          = PH_CTYPE;
      end
      PH_CTYPE: begin
        held_class_type_next  = item.data_byte;
        object_remaining_next = plen;
        if (plen == 16'd0) begin
          phase_next = PH_LEN_HI;
        end else if (object_length < 16'(MIN_OBJECT_BYTES)) begin
          phase_next = PH_SKIP;
        end else begin
          phase_next = PH_KEEP;
        end
      end
      PH_KEEP: begin
        emit                  = 1'b1;
        object_remaining_next = object_remaining - 16'd1;
        if (object_remaining == 16'd1) begin
          phase_next = PH_LEN_HI;
        end
      end
      PH_SKIP: begin
        object_remaining_next = object_remaining - 16'd1;
        if (object_remaining == 16'd1) begin
          phase_next = PH_LEN_HI;
        end
      end
      default: begin
      end
    endcase

    byte_offset_next    = (off != 16'hFFFF) ? off + 16'd1 : off;
    latched_length_next = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_STOPPED;
      byte_offset      <= '0;
      latched_length   <= '0;
      object_length    <= '0;
      object_remaining <= '0;
      held_class_num   <= '0;
      held_class_type  <= '0;
      res_valid        <= 1'b0;
    end else if (item_take) begin
      phase            <= phase_next;
      byte_offset      <= byte_offset_next;
      latched_length   <= latched_length_next;
      object_length    <= object_length_next;
      object_remaining <= object_remaining_next;
      held_class_num   <= held_class_num_next;
      held_class_type  <= held_class_type_next;
      res_valid        <= emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (item_take && emit) begin
      res <= res_next;
    end
  end

endmodule

[sv/icmp_extension_object_parser.sv]
`timescale 1ns / 1ps

// ICMP extension object parser.
// The slave channel carries the extension structure one byte per transfer;
// tuser marks the first byte and total_length is sampled with it. The block
// skips the extension header, walks the objects and, for every payload byte
// of an object that is long enough and fits the structure, sends one
// transfer on the master channel with the object's class number, C-type,
// payload length and the byte's position; tlast marks the object's last byte.
// Header bytes, short objects and bytes after the walk ends give no transfer.
// Each byte is registered in the input register, then goes through the walk logic
// into the result register, from which its result is transferred.
// Throughput: one byte per cycle while the master side does not stall, set by the
// single walk step between the input register and the result register.
// A stalled master side holds its result; an empty input register still takes one
// more byte, after which s_tready falls until the result is taken.
// Reset clears both valid flags and leaves the walker waiting for a first byte.
module icmp_extension_object_parser
  import iceop_pkg::*;
#(
  parameter int EXT_HEADER_BYTES = EXT_HEADER_BYTES_DEF,
  parameter int MIN_OBJECT_BYTES = MIN_OBJECT_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // data_byte, total_length
  input  logic                  s_tuser,  // packet_start
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // class_num, class_type, payload_length,
                                          // payload_index, payload_byte
  output logic                  m_tlast
);

  iceop_item_t   in_item;
  iceop_item_t   held_item;
  logic          held_valid;
  logic          held_take;
  iceop_result_t res;

  always_comb begin
    in_item.data_byte    = s_tdata[7:0];
    in_item.total_length = s_tdata[23:8];
    in_item.packet_start = s_tuser;
  end

  iceop_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_take  (held_take),
    .held_item  (held_item)
  );

  iceop_walker #(
    .EXT_HEADER_BYTES (EXT_HEADER_BYTES),
    .MIN_OBJECT_BYTES (MIN_OBJECT_BYTES)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .item_valid (held_valid),
    .item_take  (held_take),
    .item       (held_item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {res.payload_byte, res.payload_index, res.payload_length,
                    res.class_type, res.class_num};
  assign m_tlast = res.object_last;

  // A result always lies inside its object's payload.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.payload_index < res.payload_length)
    else $error("payload index beyond payload length");

  // The last byte flag sits exactly on the final payload position.
  a_last_position: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.object_last == (res.payload_index == res.payload_length - 16'd1)))
    else $error("object_last does not match payload position");

  // Only objects of at least the minimum length produce results.
  a_min_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.payload_length >= 16'(MIN_OBJECT_BYTES) - OBJ_HEADER_BYTES)
    else $error("result from an object shorter than the minimum");

  // The walker never takes an item while a result waits on a stalled output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !held_take)
    else $error("walker advanced over a stalled result");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import iceop_pkg::*;

  typedef enum logic [2:0] {
    WALK_STOPPED,
    WALK_HEADER,
    WALK_LEN_HI,
    WALK_LEN_LO,
    WALK_CLASS,
    WALK_CTYPE,
    WALK_KEEP,
    WALK_SKIP
  } walk_phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic [15:0] total;
  } stream_byte_t;

  // Walks the structure byte by byte and keeps the payload transfers still owed by the block.
  class object_payload_scoreboard;
    walk_phase_t     phase = WALK_STOPPED;
    logic [15:0]     offset = '0;
    logic [15:0]     struct_len = '0;
    logic [15:0]     obj_len = '0;
    logic [15:0]     remaining = '0;
    logic [7:0]      held_num = '0;
    logic [7:0]      held_type = '0;
    iceop_result_t   payloads_due[$];
    int unsigned     mismatches = 0;

    task report(string msg);
      if (mismatches < 40) $display("ERROR %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Returns 1 when the byte falls inside a structure that is still being walked.
    function bit take_byte(logic [7:0] data, logic first, logic [15:0] total);
      int unsigned   off;
      int unsigned   len;
      logic [15:0]   plen;
      iceop_result_t due;
      bit            walking;
      if (first) begin
        offset = '0;
        struct_len = total;
        phase = WALK_HEADER;
      end
      off = 32'(offset);
      len = 32'(struct_len);
      walking = (phase != WALK_STOPPED);
      if (phase == WALK_HEADER && off >= EXT_HEADER_BYTES_DEF) phase = WALK_LEN_HI;
      case (phase)
        WALK_LEN_HI: begin
          // A new object needs more than its own header left in the structure.
          if (off + OBJ_HEADER_BYTES >= len) begin
            phase = WALK_STOPPED;
          end else begin
            obj_len = {data, 8'h00};
            phase = WALK_LEN_LO;
          end
        end
        WALK_LEN_LO: begin
          obj_len = obj_len | {8'h00, data};
          if (obj_len < OBJ_HEADER_BYTES || (off - 1) + obj_len > len) phase = WALK_STOPPED;
          else phase = WALK_CLASS;
        end
        WALK_CLASS: begin
          held_num = data;
          phase = WALK_CTYPE;
        end
        WALK_CTYPE: begin
          held_type = data;
          remaining = obj_len - OBJ_HEADER_BYTES;
          if (remaining == 0) phase = WALK_LEN_HI;
          else if (obj_len < MIN_OBJECT_BYTES_DEF) phase = WALK_SKIP;
          else phase = WALK_KEEP;
        end
        WALK_KEEP: begin
          plen = obj_len - OBJ_HEADER_BYTES;
          due.class_num = held_num;
          due.class_type = held_type;
          due.payload_length = plen;
          due.payload_index = plen - remaining;
          due.payload_byte = data;
          due.object_last = (remaining == 16'd1);
          payloads_due.push_back(due);
          remaining = remaining - 16'd1;
          if (remaining == 0) phase = WALK_LEN_HI;
        end
        WALK_SKIP: begin
          remaining = remaining - 16'd1;
          if (remaining == 0) phase = WALK_LEN_HI;
        end
        default: ;
      endcase
      if (offset != 16'hFFFF) offset = offset + 16'd1;
      return walking;
    endfunction

    task check_payload(iceop_result_t got);
      iceop_result_t want;
      if (payloads_due.size() == 0) begin
        report($sformatf("payload transfer with nothing outstanding: %h", got));
      end else begin
        want = payloads_due.pop_front();
        if (got.class_num !== want.class_num)
          report($sformatf("class_num %h, wanted %h", got.class_num, want.class_num));
        if (got.class_type !== want.class_type)
          report($sformatf("class_type %h, wanted %h", got.class_type, want.class_type));
        if (got.payload_length !== want.payload_length)
          report($sformatf("payload_length %0d, wanted %0d",
                           got.payload_length, want.payload_length));
        if (got.payload_index !== want.payload_index)
          report($sformatf("payload_index %0d, wanted %0d",
                           got.payload_index, want.payload_index));
        if (got.payload_byte !== want.payload_byte)
          report($sformatf("payload_byte %h, wanted %h", got.payload_byte, want.payload_byte));
        if (got.object_last !== want.object_last)
          report($sformatf("tlast %b, wanted %b", got.object_last, want.object_last));
      end
    endtask

    function int unsigned outstanding();
      return payloads_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  object_payload_scoreboard sb = new();
  stream_byte_t             stream_q[$];
  bit                       idle_on = 1'b1;
  int unsigned              walked = 0;

  icmp_extension_object_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial forever #1 clk = ~clk;

  function automatic void add_byte(logic [7:0] data, logic first, logic [15:0] total);
    stream_byte_t item;
    item.data = data;
    item.first = first;
    item.total = total;
    stream_q.push_back(item);
  endfunction

  function automatic void add_header(logic [15:0] total);
    add_byte(8'($urandom_range(0, 255)), 1'b1, total);
    for (int i = 1; i < EXT_HEADER_BYTES_DEF; i++)
      add_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
  endfunction

  function automatic void add_object(logic [15:0] olen, logic [7:0] cnum, logic [7:0] ctype,
                                     int unsigned npay);
    add_byte(olen[15:8], 1'b0, 16'($urandom_range(0, 65535)));
    add_byte(olen[7:0], 1'b0, 16'($urandom_range(0, 65535)));
    add_byte(cnum, 1'b0, 16'($urandom_range(0, 65535)));
    add_byte(ctype, 1'b0, 16'($urandom_range(0, 65535)));
    for (int unsigned i = 0; i < npay; i++)
      add_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
  endfunction

  // Mostly well-formed structures; some are damaged so that every stop condition is hit.
  function automatic void add_random_structure();
    int unsigned hdr_idx;
    int unsigned body_idx;
    int unsigned total;
    int unsigned olen;
    int unsigned npay;
    int unsigned pick;
    int unsigned extra;
    logic [15:0] tlen;
    hdr_idx = stream_q.size();
    add_header(16'h0000);
    body_idx = stream_q.size();
    total = EXT_HEADER_BYTES_DEF;
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) olen = $urandom_range(8, 24);
      else if (pick < 16) olen = $urandom_range(4, 7);
      else if (pick < 18) olen = $urandom_range(25, 200);
      else if (pick < 19) olen = $urandom_range(0, 3);
      else olen = $urandom_range(0, 65535);
      npay = (olen >= 4) ? olen - 4 : 0;
      if (npay > 300) npay = 300;
      add_object(olen[15:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), npay);
      total += 4 + npay;
    end
    tlen = total[15:0];
    case ($urandom_range(0, 9))
      0: tlen = 16'($urandom_range(0, 65535));
      1: tlen = (total > 6) ? 16'(total - $urandom_range(1, 6)) : total[15:0];
      2: begin
        extra = $urandom_range(1, 12);
        tlen = 16'(total + extra);
        repeat (extra)
          add_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
      end
      3: begin
        // Cut short; the next structure starts in the middle of this one.
        extra = $urandom_range(0, stream_q.size() - body_idx);
        while (stream_q.size() > body_idx + extra) void'(stream_q.pop_back());
      end
      4: stream_q[$urandom_range(body_idx, stream_q.size() - 1)].data =
           8'($urandom_range(0, 255));
      default: ;
    endcase
    stream_q[hdr_idx].total = tlen;
  endfunction

  task automatic send_byte(stream_byte_t item);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {item.total, item.data};
    s_tuser <= item.first;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    void'(sb.take_byte(item.data, item.first, item.total));
    walked++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // Receiver: a random stall before each transfer it takes while idle_on is set.
  initial begin
    int unsigned stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_payload(iceop_result_t'({m_tlast, m_tdata}));
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bytes ahead of any first byte are dropped.
    add_byte(8'hFF, 1'b0, 16'hFFFF);
    add_byte(8'h00, 1'b0, 16'h0000);
    // Kept object, short skipped object, empty object, then the end of the structure.
    add_header(16'd21);
    add_object(16'd8, 8'hFF, 8'h00, 4);
    add_object(16'd5, 8'h00, 8'hFF, 1);
    add_object(16'd4, 8'h81, 8'h7E, 0);
    add_byte(8'h5A, 1'b0, 16'h0000);
    // Length field below four.
    add_header(16'hFFFF);
    add_byte(8'h00, 1'b0, 16'h0000);
    add_byte(8'h02, 1'b0, 16'h0000);
    // Object running past the end of the structure.
    add_header(16'd12);
    add_byte(8'h00, 1'b0, 16'h0000);
    add_byte(8'h09, 1'b0, 16'h0000);
    send_stream();

    // A long kept object sent with no gaps on either side.
    idle_on = 1'b0;
    add_header(16'hFFFF);
    add_object(16'd204, 8'hA5, 8'h5A, 200);
    repeat (3) add_byte(8'($urandom_range(0, 255)), 1'b0, 16'hFFFF);
    send_stream();

    while (walked < 1800) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                   16'($urandom_range(0, 65535)));
      end else begin
        add_random_structure();
      end
      send_stream();
    end

    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("icmp_extension_object_parser verification clean");
    end else begin
      $display("icmp_extension_object_parser verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("icmp_extension_object_parser verification failed");
    $finish;
  end

endmodule
